// File: design/fpp_pkg.sv
// Package for the FEN position parser: character codes, field numbers,
// piece codes, the letter decoder and the controller/datapath command types.
// No dependencies.
`default_nettype none

package fpp_pkg;

  localparam int unsigned CounterBitsDef = 16;
  localparam int unsigned Squares        = 64;
  localparam int unsigned SqW            = 6;
  localparam int unsigned PieceW         = 4;
  localparam int unsigned OutDataW       = 256;

  // Character codes used by the parser.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChFileA = 8'h61;
  localparam logic [7:0] ChFileH = 8'h68;
  localparam logic [7:0] ChBlack = 8'h62;
  localparam logic [7:0] ChWK    = 8'h4B;
  localparam logic [7:0] ChWQ    = 8'h51;
  localparam logic [7:0] ChBK    = 8'h6B;
  localparam logic [7:0] ChBQ    = 8'h71;

  // Field numbers of the FEN record.
  localparam logic [2:0] FldPlace  = 3'd0;
  localparam logic [2:0] FldSide   = 3'd1;
  localparam logic [2:0] FldCastle = 3'd2;
  localparam logic [2:0] FldEp     = 3'd3;
  localparam logic [2:0] FldHalf   = 3'd4;
  localparam logic [2:0] FldFull   = 3'd5;
  localparam logic [2:0] FldExtra  = 3'd6;

  localparam logic signed [3:0] PcEmpty = 4'sd0;
  localparam logic signed [3:0] PcWKing = 4'sd6;
  localparam logic signed [3:0] PcBKing = -4'sd6;

  localparam logic [6:0] EpNone = 7'h7F;

  typedef struct packed {
    logic take;   // process the character on the input
    logic rd;     // read the store at the emit index
    logic load;   // load the result register
    logic next;   // step to the next square
    logic clear;  // return all parse state to reset
  } fpp_cmd_t;

  typedef struct packed {
    logic last_sq;  // emit index is at the final square
  } fpp_stat_t;

  function automatic logic signed [3:0] letter_code(input logic [7:0] c);
    logic signed [3:0] code;
    case (c)
      "P":     code = 4'sd1;
      "N":     code = 4'sd2;
      "B":     code = 4'sd3;
      "R":     code = 4'sd4;
      "Q":     code = 4'sd5;
      "K":     code = PcWKing;
      "p":     code = -4'sd1;
      "n":     code = -4'sd2;
      "b":     code = -4'sd3;
      "r":     code = -4'sd4;
      "q":     code = -4'sd5;
      "k":     code = PcBKing;
      default: code = PcEmpty;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: design/fpp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module fpp_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/fpp_ctrl.sv
// Sequencer of the FEN position parser: accepts characters, then steps
// the datapath through the 64-square dump. Depends on fpp_pkg.
`default_nettype none

module fpp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic              s_tlast_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  input  wire fpp_pkg::fpp_stat_t stat_i,
  output fpp_pkg::fpp_cmd_t      cmd_o
);
  import fpp_pkg::*;

  typedef enum logic [1:0] {
    StParse,
    StFetch,
    StLoad,
    StSend
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StParse;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        StParse: begin
          if (s_tvalid_i && ready_q && s_tlast_i) begin
            state_q <= StFetch;
            ready_q <= 1'b0;
          end
        end
        StFetch: begin
          state_q <= StLoad;
        end
        StLoad: begin
          state_q <= StSend;
          valid_q <= 1'b1;
        end
        StSend: begin
          if (m_tready_i) begin
            valid_q <= 1'b0;
            if (stat_i.last_sq) begin
              state_q <= StParse;
              ready_q <= 1'b1;
            end else begin
              state_q <= StFetch;
            end
          end
        end
        default: begin
          state_q <= StParse;
          ready_q <= 1'b1;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.take  = s_tvalid_i && ready_q;
    cmd_o.rd    = (state_q == StFetch);
    cmd_o.load  = (state_q == StLoad);
    cmd_o.next  = (state_q == StSend) && m_tready_i && !stat_i.last_sq;
    cmd_o.clear = (state_q == StSend) && m_tready_i && stat_i.last_sq;
  end

  assign s_tready_o = ready_q;
  assign m_tvalid_o = valid_q;

`ifndef ASSERT_OFF
  // Input and output sides are never open at the same time.
  a_ready_xor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_q && valid_q))
    else $error("input ready while a result is pending");

  // The final character closes the input until the dump is over.
  a_last_char_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && ready_q && s_tlast_i) |=> !ready_q)
    else $error("input still open after final character");

  // Delivery of the final square reopens the input.
  a_dump_done_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && m_tready_i && stat_i.last_sq) |=> (ready_q && !valid_q))
    else $error("input not reopened after final square");
`endif

endmodule

`default_nettype wire

// File: design/fpp_dp.sv
// Datapath of the FEN position parser: field tracking, placement store with
// valid bits, occupancy masks, counters and the result register.
// Depends on fpp_pkg and fpp_ram.
`default_nettype none

module fpp_dp #(
  parameter int unsigned CounterBits = fpp_pkg::CounterBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fpp_pkg::fpp_cmd_t              cmd_i,
  input  wire logic [7:0]                     char_i,
  output fpp_pkg::fpp_stat_t                  stat_o,
  output logic [fpp_pkg::OutDataW-1:0]        tdata_o,
  output logic                                tlast_o
);
  import fpp_pkg::*;

  localparam int unsigned AccW = (CounterBits < 16) ? CounterBits : 16;
  localparam logic [AccW-1:0] AccMax = '1;

  logic [Squares-1:0] vld_q, vld_d;
  logic [63:0]        white_q, white_d, black_q, black_d;
  logic [SqW-1:0]     wk_q, wk_d, bk_q, bk_d;
  logic [2:0]         field_q, field_d;
  logic [3:0]         rank_q, rank_d, file_q, file_d;
  logic               in_tok_q, in_tok_d, black_mv_q, black_mv_d;
  logic [3:0]         castle_q, castle_d;
  logic [1:0]         ep_cnt_q, ep_cnt_d;
  logic [7:0]         ep_f_q, ep_f_d, ep_r_q, ep_r_d;
  logic               stop_q, stop_d;
  logic [AccW-1:0]    half_q, half_d, full_q, full_d;
  logic [SqW-1:0]     idx_q;
  logic               ok_q;
  logic signed [3:0]  piece_q;
  logic               last_q;

  logic               first, stop_eff, is_digit, is_num, on_board;
  logic [SqW-1:0]     sq;
  logic signed [3:0]  code;
  logic [4:0]         file_end;
  logic [AccW-1:0]    acc_sel;
  logic [AccW+3:0]    acc_sum;
  logic [AccW-1:0]    acc_new;
  logic               ram_we;
  logic [PieceW-1:0]  ram_rdata;

  assign first    = !in_tok_q;
  assign stop_eff = first ? 1'b0 : stop_q;
  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_num   = (char_i >= ChOne) && (char_i <= ChNine);
  assign on_board = (rank_q < 4'd8) && (file_q < 4'd8);
  assign sq       = {~rank_q[2:0], file_q[2:0]};
  assign code     = letter_code(char_i);
  assign file_end = {1'b0, file_q} + {1'b0, char_i[3:0]};

  // One decimal step: acc * 10 + digit, saturated at the counter limit.
  assign acc_sel = (field_q == FldHalf) ? half_q : full_q;
  assign acc_sum = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                 + {{AccW{1'b0}}, char_i[3:0]};
  assign acc_new = (acc_sum > {4'b0000, AccMax}) ? AccMax : acc_sum[AccW-1:0];

  assign ram_we = cmd_i.take && (char_i != ChSpace) && (field_q == FldPlace)
               && (char_i != ChSlash) && !is_num && on_board;

  always_comb begin
    vld_d      = vld_q;
    white_d    = white_q;
    black_d    = black_q;
    wk_d       = wk_q;
    bk_d       = bk_q;
    field_d    = field_q;
    rank_d     = rank_q;
    file_d     = file_q;
    in_tok_d   = in_tok_q;
    black_mv_d = black_mv_q;
    castle_d   = castle_q;
    ep_cnt_d   = ep_cnt_q;
    ep_f_d     = ep_f_q;
    ep_r_d     = ep_r_q;
    stop_d     = stop_q;
    half_d     = half_q;
    full_d     = full_q;

    if (cmd_i.clear) begin
      vld_d      = '0;
      white_d    = '0;
      black_d    = '0;
      wk_d       = '0;
      bk_d       = '0;
      field_d    = FldPlace;
      rank_d     = '0;
      file_d     = '0;
      in_tok_d   = 1'b0;
      black_mv_d = 1'b0;
      castle_d   = '0;
      ep_cnt_d   = '0;
      ep_f_d     = '0;
      ep_r_d     = '0;
      stop_d     = 1'b0;
      half_d     = '0;
      full_d     = '0;
    end else if (cmd_i.take) begin
      if (char_i == ChSpace) begin
        if (in_tok_q) begin
          in_tok_d = 1'b0;
          if (field_q < FldExtra) begin
            field_d = field_q + 3'd1;
          end
        end
      end else begin
        in_tok_d = 1'b1;
        stop_d   = stop_eff;
        case (field_q)
          FldPlace: begin
            if (char_i == ChSlash) begin
              if (rank_q < 4'd8) begin
                rank_d = rank_q + 4'd1;
              end
              file_d = '0;
            end else if (is_num) begin
              // A run of empty squares, cut off at the edge of the board.
              for (int j = 0; j < 8; j++) begin
                if ((rank_q < 4'd8) && (5'(j) >= {1'b0, file_q}) && (5'(j) < file_end)) begin
                  vld_d[{~rank_q[2:0], 3'(j)}] = 1'b0;
                end
              end
              file_d = (file_end > 5'd8) ? 4'd8 : file_end[3:0];
            end else if (file_q < 4'd8) begin
              if (rank_q < 4'd8) begin
                vld_d[sq] = 1'b1;
                if (code > PcEmpty) begin
                  white_d[sq] = 1'b1;
                  if (code == PcWKing) begin
                    wk_d = sq;
                  end
                end else if (code < PcEmpty) begin
                  black_d[sq] = 1'b1;
                  if (code == PcBKing) begin
                    bk_d = sq;
                  end
                end
              end
              file_d = file_q + 4'd1;
            end
          end
          FldSide: begin
            if (first && (char_i == ChBlack)) begin
              black_mv_d = 1'b1;
            end
          end
          FldCastle: begin
            case (char_i)
              ChWK:    castle_d = castle_q | 4'b0001;
              ChWQ:    castle_d = castle_q | 4'b0010;
              ChBK:    castle_d = castle_q | 4'b0100;
              ChBQ:    castle_d = castle_q | 4'b1000;
              default: castle_d = castle_q;
            endcase
          end
          FldEp: begin
            if (ep_cnt_q != 2'd3) begin
              if (ep_cnt_q == 2'd0) begin
                ep_f_d = char_i;
              end else if (ep_cnt_q == 2'd1) begin
                ep_r_d = char_i;
              end
              ep_cnt_d = ep_cnt_q + 2'd1;
            end
          end
          FldHalf, FldFull: begin
            if (first && ((char_i == ChPlus) || (char_i == ChMinus))) begin
              stop_d = 1'b0;
            end else if (is_digit && !stop_eff) begin
              if (field_q == FldHalf) begin
                half_d = acc_new;
              end else begin
                full_d = acc_new;
              end
            end else begin
              stop_d = 1'b1;
            end
          end
          default: begin
            stop_d = stop_eff;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      white_q    <= '0;
      black_q    <= '0;
      wk_q       <= '0;
      bk_q       <= '0;
      field_q    <= FldPlace;
      rank_q     <= '0;
      file_q     <= '0;
      in_tok_q   <= 1'b0;
      black_mv_q <= 1'b0;
      castle_q   <= '0;
      ep_cnt_q   <= '0;
      ep_f_q     <= '0;
      ep_r_q     <= '0;
      stop_q     <= 1'b0;
      half_q     <= '0;
      full_q     <= '0;
      idx_q      <= '0;
    end else begin
      vld_q      <= vld_d;
      white_q    <= white_d;
      black_q    <= black_d;
      wk_q       <= wk_d;
      bk_q       <= bk_d;
      field_q    <= field_d;
      rank_q     <= rank_d;
      file_q     <= file_d;
      in_tok_q   <= in_tok_d;
      black_mv_q <= black_mv_d;
      castle_q   <= castle_d;
      ep_cnt_q   <= ep_cnt_d;
      ep_f_q     <= ep_f_d;
      ep_r_q     <= ep_r_d;
      stop_q     <= stop_d;
      half_q     <= half_d;
      full_q     <= full_d;
      if (cmd_i.clear) begin
        idx_q <= '0;
      end else if (cmd_i.next) begin
        idx_q <= idx_q + 6'd1;
      end
    end
  end

  fpp_ram #(
    .Width(PieceW),
    .Depth(Squares)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(sq),
    .wdata_i(code),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  // An entry without its valid bit is an empty square.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      ok_q <= vld_q[idx_q];
    end
    if (cmd_i.load) begin
      piece_q <= ok_q ? $signed(ram_rdata) : PcEmpty;
      last_q  <= &idx_q;
    end
  end

  logic [63:0]    own_mask, other_mask;
  logic [SqW-1:0] own_king, other_king;
  logic           ep_ok;
  logic [6:0]     ep_sq;

  assign own_mask   = black_mv_q ? black_q : white_q;
  assign other_mask = black_mv_q ? white_q : black_q;
  assign own_king   = black_mv_q ? bk_q : wk_q;
  assign other_king = black_mv_q ? wk_q : bk_q;
  assign ep_ok      = (ep_cnt_q == 2'd2) && (ep_f_q >= ChFileA) && (ep_f_q <= ChFileH)
                   && (ep_r_q >= ChOne) && (ep_r_q <= ChEight);
  assign ep_sq      = ep_ok ? {1'b0, ep_r_q[2:0] - ChOne[2:0], ep_f_q[2:0] - ChFileA[2:0]}
                            : EpNone;

  assign tdata_o = {4'b0000, 16'(full_q), 16'(half_q), ep_sq, castle_q, black_mv_q,
                    other_king, own_king, own_mask | other_mask, other_mask, own_mask,
                    piece_q};
  assign tlast_o = last_q;
  assign stat_o.last_sq = &idx_q;

endmodule

`default_nettype wire

// File: design/fen_position_parser_unit.sv
// FEN position parser, top level; depends on fpp_pkg, fpp_ctrl, fpp_dp, fpp_ram.
// Throughput: one text character per cycle, ready is held high while parsing.
// After the character flagged as last, the 64-square dump starts: each result
// goes through store read, result load and hand-off, and the hand-off waits out any output stall.
// Reset (rst_ni low, asynchronous) clears all parse state and the store's valid bits.
`default_nettype none

module fen_position_parser_unit #(
  parameter int unsigned COUNTER_BITS = fpp_pkg::CounterBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input stream. tdata: [7:0] char_code. tlast: end_of_text.
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,
  input  wire logic                         s_axis_tlast_i,
  // Result stream, one item per square 0..63.
  // tdata from bit 0 up: piece[3:0], own_mask[67:4], other_mask[131:68],
  // occupied_mask[195:132], own_king[201:196], other_king[207:202],
  // black_to_move[208], castle_rights[212:209], en_passant[219:213],
  // half_moves[235:220], full_moves[251:236], zero fill [255:252].
  // tlast: last_square.
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [fpp_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import fpp_pkg::*;

  fpp_cmd_t  cmd;
  fpp_stat_t stat;

  // The controller owns the handshakes; the datapath only follows commands.
  fpp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tlast_i (s_axis_tlast_i),
    .s_tready_o(s_axis_tready_o),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // The summary fields come straight from the parse registers, which hold
  // still for the whole dump; only the piece code and last flag are loaded
  // per square.
  fpp_dp #(
    .CounterBits(COUNTER_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .char_i (s_axis_tdata_i),
    .stat_o (stat),
    .tdata_o(m_axis_tdata_o),
    .tlast_o(m_axis_tlast_o)
  );

endmodule

`default_nettype wire
